/* rtl/core/htfd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htfd_pkg
// Shared constants, types and register map for the humidity and temperature
// frame decoder.
// ----------------------------------------------------------------------------
package htfd_pkg;

    // frame layout
    localparam int FRAME_DATA_BYTES = 6;
    localparam int IDX_W            = 3;
    localparam logic [IDX_W-1:0] IDX_FIRST     = 3'd0;
    localparam logic [IDX_W-1:0] IDX_LAST_DATA = 3'd5;
    localparam logic [IDX_W-1:0] IDX_CRC       = 3'd6;

    // crc-8, msb first, no final xor
    localparam logic [7:0] CRC_POLY = 8'h31;
    localparam logic [7:0] CRC_INIT = 8'hFF;

    // raw values and scaling
    localparam int RAW_W       = 20;
    localparam int HUM_W       = 14;
    localparam int TEMP_W      = 15;
    localparam int HUM_PROD_W  = 34;
    localparam int TEMP_PROD_W = 35;
    localparam logic [RAW_W-1:0]  RAW_FULL    = 20'hFFFFF;
    localparam logic [HUM_W-1:0]  HUM_SCALE   = 14'd10000;
    localparam logic [TEMP_W-1:0] TEMP_SCALE  = 15'd20000;
    localparam logic [TEMP_W-1:0] TEMP_OFFSET = 15'd5000;

    // queue depths
    localparam int MID_DEPTH_DEF = 2;
    localparam int OUT_DEPTH_DEF = 4;

    // register map
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic REG_CRC_EN = 1'b0;
    localparam logic CRC_EN_RESET = 1'b1;

    // completed frame passed from front to back
    typedef struct packed {
        logic [7:0]       status;
        logic [RAW_W-1:0] hum_raw;
        logic [RAW_W-1:0] temp_raw;
        logic             ok;
    } t_frame;

    // finished result
    typedef struct packed {
        logic [7:0]               status;
        logic [RAW_W-1:0]         hum_raw;
        logic [RAW_W-1:0]         temp_raw;
        logic [HUM_W-1:0]         hum_centi;
        logic signed [TEMP_W-1:0] temp_centi;
        logic                     ok;
    } t_result;

endpackage

/* rtl/core/htfd_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htfd_fifo
// Small register-based first-in first-out queue with full and empty flags.
// ----------------------------------------------------------------------------
module htfd_fifo #(
    parameter int DEPTH = 2,
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_rdata,
    output logic             o_full,
    output logic             o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CNT_FULL);
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_rdata = r_mem[r_rd_ptr];

    // pointer and count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

endmodule

/* rtl/core/htfd_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htfd_front
// Byte intake: tracks frame position, stores frame bytes, runs the crc and
// emits one frame record per completed frame.
// ----------------------------------------------------------------------------
module htfd_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [7:0]        i_rx_byte,
    input  logic              i_frame_first,
    input  logic              i_crc_en,
    input  logic              i_q_full,
    output logic              o_full,
    output logic              o_q_push,
    output htfd_pkg::t_frame  o_q_frame
);

    logic [7:0]                 r_bytes [htfd_pkg::FRAME_DATA_BYTES];
    logic [htfd_pkg::IDX_W-1:0] r_idx, n_idx;
    logic [7:0]                 r_crc, n_crc;

    logic [htfd_pkg::IDX_W-1:0] base_idx;
    logic [htfd_pkg::IDX_W-1:0] idx;
    logic [7:0]                 base_crc;
    logic [7:0]                 crc_new;
    logic                       store;
    logic                       last;
    logic                       accept;
    logic [7:0]                 view [htfd_pkg::FRAME_DATA_BYTES];

    // bitwise crc-8 over one byte
    function automatic logic [7:0] crc_update(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            c = c[7] ? ({c[6:0], 1'b0} ^ htfd_pkg::CRC_POLY) : {c[6:0], 1'b0};
        end
        return c;
    endfunction

    assign o_full = i_q_full;
    assign accept = i_push && !i_q_full;

    // frame position and crc for this byte
    always_comb begin
        base_idx = i_frame_first ? htfd_pkg::IDX_FIRST : r_idx;
        base_crc = i_frame_first ? htfd_pkg::CRC_INIT : r_crc;
        idx      = base_idx;
        if (!i_crc_en && (base_idx > htfd_pkg::IDX_LAST_DATA)) begin
            idx = htfd_pkg::IDX_LAST_DATA;
        end
        store   = (idx <= htfd_pkg::IDX_LAST_DATA);
        crc_new = crc_update(base_crc, i_rx_byte);
        last    = i_crc_en ? (idx >= htfd_pkg::IDX_CRC) : (idx == htfd_pkg::IDX_LAST_DATA);
    end

    // next position and crc
    always_comb begin
        n_idx = r_idx;
        n_crc = r_crc;
        if (accept) begin
            if (last) begin
                n_idx = htfd_pkg::IDX_FIRST;
                n_crc = htfd_pkg::CRC_INIT;
            end else begin
                n_idx = idx + 1'b1;
                n_crc = crc_new;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= htfd_pkg::IDX_FIRST;
            r_crc <= htfd_pkg::CRC_INIT;
        end else begin
            r_idx <= n_idx;
            r_crc <= n_crc;
        end
    end

    // frame byte storage
    always_ff @(posedge i_clk) begin
        if (accept && store) begin
            r_bytes[idx] <= i_rx_byte;
        end
    end

    // frame bytes including the one arriving now
    always_comb begin
        for (int k = 0; k < htfd_pkg::FRAME_DATA_BYTES; k++) begin
            view[k] = (store && (idx == htfd_pkg::IDX_W'(k))) ? i_rx_byte : r_bytes[k];
        end
    end

    // frame record
    always_comb begin
        o_q_push           = accept && last;
        o_q_frame.status   = view[0];
        o_q_frame.hum_raw  = {view[1], view[2], view[3][7:4]};
        o_q_frame.temp_raw = {view[3][3:0], view[4], view[5]};
        o_q_frame.ok       = !i_crc_en || (base_crc == i_rx_byte);
    end

endmodule

/* rtl/core/htfd_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htfd_back
// Scaling pipeline: multiplies the raw values, divides by the full-scale
// value 2^20-1 through a shift and one correction, and applies the crc mask.
// ----------------------------------------------------------------------------
module htfd_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_empty,
    input  htfd_pkg::t_frame  i_q_frame,
    output logic              o_q_pop,
    input  logic              i_out_full,
    output logic              o_out_push,
    output htfd_pkg::t_result o_out_result
);

    logic                                 r_s1_valid;
    htfd_pkg::t_frame                     r_s1_frame;
    logic [htfd_pkg::HUM_PROD_W-1:0]      r_hum_prod;
    logic [htfd_pkg::TEMP_PROD_W-1:0]     r_temp_prod;

    logic [htfd_pkg::HUM_W-1:0]           hum_q0;
    logic [htfd_pkg::TEMP_W-1:0]          temp_q0;
    logic [htfd_pkg::RAW_W:0]             hum_sum;
    logic [htfd_pkg::RAW_W:0]             temp_sum;
    logic [htfd_pkg::HUM_W-1:0]           hum_centi;
    logic [htfd_pkg::TEMP_W-1:0]          temp_floor;
    logic                                 s1_move;

    // stage handshake
    assign o_out_push = r_s1_valid && !i_out_full;
    assign s1_move    = !r_s1_valid || !i_out_full;
    assign o_q_pop    = !i_q_empty && s1_move;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_move) begin
            r_s1_valid <= o_q_pop;
        end
    end

    // multiply stage
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_s1_frame  <= i_q_frame;
            r_hum_prod  <= htfd_pkg::HUM_PROD_W'(i_q_frame.hum_raw)
                         * htfd_pkg::HUM_PROD_W'(htfd_pkg::HUM_SCALE);
            r_temp_prod <= htfd_pkg::TEMP_PROD_W'(i_q_frame.temp_raw)
                         * htfd_pkg::TEMP_PROD_W'(htfd_pkg::TEMP_SCALE);
        end
    end

    // floor(x / (2^20-1)) = q0 + ((q0 + r) >= 2^20-1), q0 = x >> 20, r = x mod 2^20
    always_comb begin
        hum_q0     = r_hum_prod[htfd_pkg::HUM_PROD_W-1:htfd_pkg::RAW_W];
        temp_q0    = r_temp_prod[htfd_pkg::TEMP_PROD_W-1:htfd_pkg::RAW_W];
        hum_sum    = {1'b0, r_hum_prod[htfd_pkg::RAW_W-1:0]}
                   + (htfd_pkg::RAW_W+1)'(hum_q0);
        temp_sum   = {1'b0, r_temp_prod[htfd_pkg::RAW_W-1:0]}
                   + (htfd_pkg::RAW_W+1)'(temp_q0);
        hum_centi  = hum_q0
                   + htfd_pkg::HUM_W'(hum_sum >= {1'b0, htfd_pkg::RAW_FULL});
        temp_floor = temp_q0
                   + htfd_pkg::TEMP_W'(temp_sum >= {1'b0, htfd_pkg::RAW_FULL});
    end

    // result with crc mask
    always_comb begin
        o_out_result.status = r_s1_frame.status;
        o_out_result.ok     = r_s1_frame.ok;
        if (r_s1_frame.ok) begin
            o_out_result.hum_raw    = r_s1_frame.hum_raw;
            o_out_result.temp_raw   = r_s1_frame.temp_raw;
            o_out_result.hum_centi  = hum_centi;
            o_out_result.temp_centi = $signed(temp_floor - htfd_pkg::TEMP_OFFSET);
        end else begin
            o_out_result.hum_raw    = '0;
            o_out_result.temp_raw   = '0;
            o_out_result.hum_centi  = '0;
            o_out_result.temp_centi = '0;
        end
    end

endmodule

/* rtl/core/humidity_temp_frame_decoder.sv */
`timescale 1ns / 1ps
// path: a result passes the frame queue, the multiply stage and the result queue
// throughput: one byte per cycle; intake stalls only when the frame queue between the
//   byte front end and the scaling pipeline is full, set by result backpressure
// reset: synchronous active-low; frame position to zero, crc to 0xff, queues emptied,
//   crc checking enabled
// ----------------------------------------------------------------------------
// humidity_temp_frame_decoder
// Decodes humidity and temperature sensor measurement frames with optional
// crc-8 check and scales the raw readings to hundredths.
// ----------------------------------------------------------------------------
module humidity_temp_frame_decoder #(
    parameter int MID_DEPTH = htfd_pkg::MID_DEPTH_DEF,
    parameter int OUT_DEPTH = htfd_pkg::OUT_DEPTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // byte input
    input  logic                              push,
    output logic                              full,
    input  logic [7:0]                        i_rx_byte,
    input  logic                              i_frame_first,
    // result output
    output logic                              empty,
    input  logic                              pop,
    output logic [7:0]                        o_status_byte,
    output logic [htfd_pkg::RAW_W-1:0]        o_humidity_raw,
    output logic [htfd_pkg::RAW_W-1:0]        o_temperature_raw,
    output logic [htfd_pkg::HUM_W-1:0]        o_humidity_centi,
    output logic signed [htfd_pkg::TEMP_W-1:0] o_temperature_centi,
    output logic                              o_crc_ok,
    // configuration
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [htfd_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [htfd_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [htfd_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready
);

    localparam int FRAME_W  = $bits(htfd_pkg::t_frame);
    localparam int RESULT_W = $bits(htfd_pkg::t_result);

    logic               r_crc_en;
    logic               reg_sel;
    logic               mid_push, mid_pop, mid_full, mid_empty;
    htfd_pkg::t_frame   mid_wframe, mid_rframe;
    logic [FRAME_W-1:0] mid_rdata;
    logic               out_push, out_full;
    htfd_pkg::t_result  out_wresult, out_rresult;
    logic [RESULT_W-1:0] out_rdata;

    // configuration register
    assign pready  = 1'b1;
    assign reg_sel = (paddr[2] == htfd_pkg::REG_CRC_EN);
    assign prdata  = reg_sel ? {{(htfd_pkg::APB_DATA_W-1){1'b0}}, r_crc_en} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc_en <= htfd_pkg::CRC_EN_RESET;
        end else if (psel && penable && pwrite && pready && reg_sel) begin
            r_crc_en <= pwdata[0];
        end
    end

    // byte intake
    htfd_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .i_rx_byte     (i_rx_byte),
        .i_frame_first (i_frame_first),
        .i_crc_en      (r_crc_en),
        .i_q_full      (mid_full),
        .o_full        (full),
        .o_q_push      (mid_push),
        .o_q_frame     (mid_wframe)
    );

    // frame queue between intake and scaling
    htfd_fifo #(
        .DEPTH (MID_DEPTH),
        .WIDTH (FRAME_W)
    ) u_mid_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (mid_push),
        .i_wdata (mid_wframe),
        .i_pop   (mid_pop),
        .o_rdata (mid_rdata),
        .o_full  (mid_full),
        .o_empty (mid_empty)
    );

    assign mid_rframe = mid_rdata;

    // scaling pipeline
    htfd_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_empty    (mid_empty),
        .i_q_frame    (mid_rframe),
        .o_q_pop      (mid_pop),
        .i_out_full   (out_full),
        .o_out_push   (out_push),
        .o_out_result (out_wresult)
    );

    // result queue
    htfd_fifo #(
        .DEPTH (OUT_DEPTH),
        .WIDTH (RESULT_W)
    ) u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (out_push),
        .i_wdata (out_wresult),
        .i_pop   (pop),
        .o_rdata (out_rdata),
        .o_full  (out_full),
        .o_empty (empty)
    );

    // result fields
    assign out_rresult         = out_rdata;
    assign o_status_byte       = out_rresult.status;
    assign o_humidity_raw      = out_rresult.hum_raw;
    assign o_temperature_raw   = out_rresult.temp_raw;
    assign o_humidity_centi    = out_rresult.hum_centi;
    assign o_temperature_centi = out_rresult.temp_centi;
    assign o_crc_ok            = out_rresult.ok;

endmodule
